// ===== src/sdrs_pkg.sv =====
package sdrs_pkg;

    // Width of the internal offset arithmetic; offsets wrap at this width.
    localparam int OFFSET_BITS = 32;

    // Result queue depth (power of two so the pointers wrap naturally).
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Maximum number of spans that one input beat can produce.
    localparam int MAX_SPANS = 2;
    localparam int SPAN_CW   = $clog2(MAX_SPANS + 1);

    // One emitted span as seen on the output channel.
    typedef struct packed {
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic        final_span;
    } span_t;

    // Spans produced by one accepted input beat, packed from entry 0 upward.
    typedef struct packed {
        logic [SPAN_CW-1:0] count;
        span_t              span1;
        span_t              span0;
    } span_pair_t;

    // Scanner status seen by the top level.
    typedef struct packed {
        logic have_section;
        logic pos_zero;
    } scan_status_t;

    // Result queue status seen by the top level.
    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               nearly_full;
    } fifo_status_t;

endpackage

// ===== src/sdrs_scanner.sv =====
module sdrs_scanner
    import sdrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output span_pair_t          spans,
    output scan_status_t        status
);

    typedef enum logic [3:0] {
        PH_LINE_START,
        PH_LINE_REST,
        PH_GOT_LT,
        PH_GOT_D,
        PH_GOT_I,
        PH_GOT_V,
        PH_WS_NAME,
        PH_NAME,
        PH_WS_EQ,
        PH_SKIP,
        PH_WS_VAL,
        PH_QVAL,
        PH_UVAL
    } phase_t;

    localparam logic [2:0] NAME_FULL  = 3'd4;
    localparam logic [2:0] NAME_FAIL  = 3'd7;
    localparam logic [3:0] VALUE_FULL = 4'd7;
    localparam logic [3:0] VALUE_FAIL = 4'd15;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_LOW_I = 8'h69;
    localparam logic [7:0] CH_LOW_V = 8'h76;

    localparam logic [7:0] WORD_TYPE [4] = '{8'h74, 8'h79, 8'h70, 8'h65};
    localparam logic [7:0] WORD_SECTION [7] =
        '{8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e};

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f) || (c == 8'h2d) ||
               (c == 8'h3a) || (c == 8'h2e);
    endfunction

    function automatic logic [2:0] next_name(input logic [2:0] m, input logic [7:0] c);
        logic [2:0] r;
        r = NAME_FAIL;
        if (m < NAME_FULL && c == WORD_TYPE[m[1:0]])
        begin
            r = m + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [3:0] next_value(input logic [3:0] m, input logic [7:0] c);
        logic [3:0] r;
        r = VALUE_FAIL;
        if (m < VALUE_FULL && c == WORD_SECTION[m[2:0]])
        begin
            r = m + 4'd1;
        end
        return r;
    endfunction

    logic [31:0]            base_reg;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    phase_t                 phase_reg, phase_next;
    logic [2:0]             name_reg, name_next;
    logic [3:0]             value_reg, value_next;
    logic [1:0]             quote_reg, quote_next;
    logic                   matched_reg, matched_next;
    logic [OFFSET_BITS-1:0] cand_reg, cand_next;
    logic [OFFSET_BITS-1:0] open_reg, open_next;
    logic                   have_reg, have_next;

    logic [OFFSET_BITS-1:0] first;
    logic [OFFSET_BITS-1:0] here;
    logic                   pair_ok;
    logic                   confirm;
    span_t                  prev_span;
    span_t                  last_span;

    assign first   = OFFSET_BITS'(base_reg);
    assign here    = first + pos_reg;
    assign pair_ok = (name_reg == NAME_FULL) && (value_reg == VALUE_FULL);

    // Tag recognizer: one step per byte.
    always_comb
    begin
        phase_next   = phase_reg;
        name_next    = name_reg;
        value_next   = value_reg;
        quote_next   = quote_reg;
        matched_next = matched_reg;
        cand_next    = cand_reg;
        confirm      = 1'b0;

        if (data_byte == CH_CR || data_byte == CH_LF)
        begin
            phase_next = PH_LINE_START;
        end
        else
        begin
            case (phase_reg)
                PH_LINE_START:
                begin
                    if (data_byte == CH_LT)
                    begin
                        cand_next  = here;
                        phase_next = PH_GOT_LT;
                    end
                    else if (data_byte != CH_SP && data_byte != CH_TAB)
                    begin
                        phase_next = PH_LINE_REST;
                    end
                end
                PH_GOT_LT:
                begin
                    phase_next = (data_byte == CH_LOW_D) ? PH_GOT_D : PH_LINE_REST;
                end
                PH_GOT_D:
                begin
                    phase_next = (data_byte == CH_LOW_I) ? PH_GOT_I : PH_LINE_REST;
                end
                PH_GOT_I:
                begin
                    phase_next = (data_byte == CH_LOW_V) ? PH_GOT_V : PH_LINE_REST;
                end
                PH_GOT_V:
                begin
                    matched_next = 1'b0;
                    name_next    = 3'd0;
                    value_next   = 4'd0;
                    quote_next   = QUOTE_NONE;
                    phase_next   = is_ws(data_byte) ? PH_WS_NAME : PH_LINE_REST;
                end
                PH_LINE_REST:
                begin
                    phase_next = PH_LINE_REST;
                end
                default:
                begin
                    // Attribute area of a candidate tag.
                    if (data_byte == CH_GT)
                    begin
                        if ((phase_reg == PH_QVAL || phase_reg == PH_UVAL) && pair_ok)
                        begin
                            matched_next = 1'b1;
                        end
                        confirm    = matched_next;
                        phase_next = PH_LINE_REST;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_WS_NAME:
                            begin
                                if (!is_ws(data_byte))
                                begin
                                    name_next = 3'd0;
                                    if (is_name_char(data_byte))
                                    begin
                                        name_next  = next_name(3'd0, data_byte);
                                        phase_next = PH_NAME;
                                    end
                                    else if (data_byte == CH_EQ)
                                    begin
                                        phase_next = PH_WS_VAL;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                            PH_NAME:
                            begin
                                if (is_name_char(data_byte))
                                begin
                                    name_next = next_name(name_reg, data_byte);
                                end
                                else if (is_ws(data_byte))
                                begin
                                    phase_next = PH_WS_EQ;
                                end
                                else if (data_byte == CH_EQ)
                                begin
                                    phase_next = PH_WS_VAL;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            PH_WS_EQ:
                            begin
                                if (data_byte == CH_EQ)
                                begin
                                    phase_next = PH_WS_VAL;
                                end
                                else if (!is_ws(data_byte))
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                            PH_SKIP:
                            begin
                                if (is_ws(data_byte))
                                begin
                                    phase_next = PH_WS_NAME;
                                end
                            end
                            PH_WS_VAL:
                            begin
                                if (!is_ws(data_byte))
                                begin
                                    value_next = 4'd0;
                                    if (data_byte == CH_DQ || data_byte == CH_SQ)
                                    begin
                                        quote_next = (data_byte == CH_DQ) ? QUOTE_DOUBLE
                                                                          : QUOTE_SINGLE;
                                        phase_next = PH_QVAL;
                                    end
                                    else
                                    begin
                                        quote_next = QUOTE_NONE;
                                        value_next = next_value(4'd0, data_byte);
                                        phase_next = PH_UVAL;
                                    end
                                end
                            end
                            PH_QVAL:
                            begin
                                if ((quote_reg == QUOTE_DOUBLE && data_byte == CH_DQ) ||
                                    (quote_reg == QUOTE_SINGLE && data_byte == CH_SQ))
                                begin
                                    if (pair_ok)
                                    begin
                                        matched_next = 1'b1;
                                    end
                                    phase_next = PH_WS_NAME;
                                end
                                else
                                begin
                                    value_next = next_value(value_reg, data_byte);
                                end
                            end
                            PH_UVAL:
                            begin
                                if (is_ws(data_byte))
                                begin
                                    if (pair_ok)
                                    begin
                                        matched_next = 1'b1;
                                    end
                                    phase_next = PH_WS_NAME;
                                end
                                else
                                begin
                                    value_next = next_value(value_reg, data_byte);
                                end
                            end
                            default:
                            begin
                                phase_next = PH_LINE_REST;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Span bookkeeping and the spans caused by this beat.
    always_comb
    begin
        open_next = open_reg;
        have_next = have_reg;
        pos_next  = pos_reg + OFFSET_BITS'(1);

        prev_span.span_start = 32'(open_reg);
        prev_span.span_end   = 32'(cand_reg - OFFSET_BITS'(1));
        prev_span.final_span = 1'b0;

        spans.count = '0;
        spans.span0 = prev_span;
        spans.span1 = prev_span;

        if (confirm)
        begin
            if (have_reg)
            begin
                spans.count = SPAN_CW'(1);
            end
            open_next = cand_reg;
            have_next = 1'b1;
        end

        last_span.span_start = 32'(have_next ? open_next : first);
        last_span.span_end   = 32'(here);
        last_span.final_span = 1'b1;

        if (last_byte)
        begin
            if (spans.count == '0)
            begin
                spans.span0 = last_span;
            end
            else
            begin
                spans.span1 = last_span;
            end
            spans.count = spans.count + SPAN_CW'(1);
        end
    end

    // Recognizer and offset state; the end of a range resets all of it but the base offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            pos_reg     <= '0;
            phase_reg   <= PH_LINE_START;
            name_reg    <= '0;
            value_reg   <= '0;
            quote_reg   <= QUOTE_NONE;
            matched_reg <= 1'b0;
            cand_reg    <= '0;
            open_reg    <= '0;
            have_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (last_byte)
                begin
                    pos_reg     <= '0;
                    phase_reg   <= PH_LINE_START;
                    name_reg    <= '0;
                    value_reg   <= '0;
                    quote_reg   <= QUOTE_NONE;
                    matched_reg <= 1'b0;
                    cand_reg    <= '0;
                    open_reg    <= '0;
                    have_reg    <= 1'b0;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    phase_reg   <= phase_next;
                    name_reg    <= name_next;
                    value_reg   <= value_next;
                    quote_reg   <= quote_next;
                    matched_reg <= matched_next;
                    cand_reg    <= cand_next;
                    open_reg    <= open_next;
                    have_reg    <= have_next;
                end
            end
        end
    end

    assign status.have_section = have_reg;
    assign status.pos_zero     = (pos_reg == '0);

endmodule

// ===== src/sdrs_out_fifo.sv =====
module sdrs_out_fifo
    import sdrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  span_pair_t   spans,
    input  logic         pop_stall,
    output logic         pop_valid,
    output span_t        head,
    output fifo_status_t status
);

    span_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [SPAN_CW-1:0] n_push;
    logic               pop;

    assign n_push    = push ? spans.count : '0;
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && !pop_stall;
    assign head      = mem[rd_ptr_reg];

    // Pointer and fill arithmetic for up to two writes and one read per cycle.
    always_comb
    begin
        wr_ptr_next = FIFO_AW'(wr_ptr_reg + FIFO_AW'(n_push));
        rd_ptr_next = pop ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = FIFO_CW'(count_reg + FIFO_CW'(n_push) - FIFO_CW'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; spans are written in order starting at the write pointer.
    always_ff @(posedge clk)
    begin
        if (n_push != '0)
        begin
            mem[wr_ptr_reg] <= spans.span0;
        end
        if (n_push == SPAN_CW'(2))
        begin
            mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= spans.span1;
        end
    end

    // Stall the producer unless a full beat's worth of spans still fits.
    assign status.count       = count_reg;
    assign status.nearly_full = (count_reg > FIFO_CW'(FIFO_DEPTH - MAX_SPANS));

endmodule

// ===== src/section_div_record_splitter.sv =====
// Section div record splitter.
//
// Bytes of one record range enter on the input channel, one per beat, with
// last_byte marking the final byte. Each line that opens with a div tag whose
// type attribute is section starts a new section; the span of the previous
// section leaves on the output channel as one beat. The last byte always
// produces a beat with final_span set, covering the open section or, when no
// section was found, the whole range. The base offset register is written
// through cfg_wdata/cfg_we; the user must do this only while the block is
// idle, as the block itself does not enforce it.
// A span enters the result queue when its byte is accepted and leaves from
// the queue head. One byte per cycle is taken while in_stall is low, also a
// byte that causes two spans; the four-entry result queue drains at one span
// per cycle while out_stall is low.
// Reset clears the recognizer, the offset counter and the queue, and sets the
// base offset to zero. While the receiver stalls, spans collect in the queue;
// in_stall rises once fewer than two entries are free.
module section_div_record_splitter
    import sdrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] span_start,
    output logic [31:0] span_end,
    output logic        final_span
);

    logic         accept;
    span_pair_t   spans;
    scan_status_t scan_status;
    fifo_status_t fifo_status;
    span_t        head;

    assign in_stall = fifo_status.nearly_full;
    assign accept   = in_valid && !in_stall;

    sdrs_scanner u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .spans     (spans),
        .status    (scan_status)
    );

    sdrs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .spans     (spans),
        .pop_stall (out_stall),
        .pop_valid (out_valid),
        .head      (head),
        .status    (fifo_status)
    );

    assign span_start = head.span_start;
    assign span_end   = head.span_end;
    assign final_span = head.final_span;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // The last byte of a range always leaves a beat waiting on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> out_valid)
        else $error("no span after last byte");

    // After the last byte the section tracking and the byte counter restart.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> !scan_status.have_section && scan_status.pos_zero)
        else $error("range state not cleared");

endmodule

// ===== test/section_div_record_splitter_tb.sv =====
`timescale 1ns / 1ps

module section_div_record_splitter_tb;
    import sdrs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Attribute name and value that mark a section tag.
    localparam logic [31:0] KEY_NAME  = "type";
    localparam logic [55:0] KEY_VALUE = "section";
    localparam logic [2:0]  NAME_MISS  = 3'd7;
    localparam logic [3:0]  VALUE_MISS = 4'd15;

    typedef logic [OFFSET_BITS-1:0] offs_t;

    typedef enum logic [3:0] {
        SC_LINE_START, SC_LINE_REST, SC_LT, SC_D, SC_I, SC_V,
        SC_ATTR_GAP, SC_ATTR_NAME, SC_EQ_GAP, SC_ATTR_SKIP, SC_VAL_GAP,
        SC_QUOTED, SC_BARE
    } scan_state_t;

    typedef enum logic [1:0] {QUOTE_NONE, QUOTE_DOUBLE, QUOTE_SINGLE} quote_t;

    typedef struct {
        logic [7:0] value;
        logic       is_last;
    } text_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'h0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic        final_span;

    section_div_record_splitter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .span_start (span_start),
        .span_end   (span_end),
        .final_span (final_span)
    );

    text_beat_t  byte_q[$];
    span_t       span_q[$];
    logic [7:0]  rec_q[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          fault_count = 0;
    int          cycle_count = 0;

    // Predicted splitter state.
    logic [31:0] base_cfg = 32'h0;
    offs_t       byte_count = '0;
    scan_state_t scan_state = SC_LINE_START;
    logic [2:0]  name_hits = 3'd0;
    logic [3:0]  value_hits = 4'd0;
    quote_t      quote_kind = QUOTE_NONE;
    logic        pair_hit = 1'b0;
    offs_t       tag_start = '0;
    offs_t       section_start = '0;
    logic        in_section = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic is_gap(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_" || c == "-" || c == ":" || c == ".";
    endfunction

    function automatic logic [2:0] next_name(input logic [2:0] m, input logic [7:0] c);
        if (m < 3'd4 && c == KEY_NAME[8 * (3 - m) +: 8])
            return m + 3'd1;
        return NAME_MISS;
    endfunction

    function automatic logic [3:0] next_value(input logic [3:0] m, input logic [7:0] c);
        if (m < 4'd7 && c == KEY_VALUE[8 * (6 - m) +: 8])
            return m + 4'd1;
        return VALUE_MISS;
    endfunction

    function automatic void check_pair();
        if (name_hits == 3'd4 && value_hits == 4'd7)
            pair_hit = 1'b1;
    endfunction

    // First byte of an attribute value: a quote opens a quoted value.
    function automatic void open_value(input logic [7:0] c);
        value_hits = 4'd0;
        if (c == "\"" || c == "'")
        begin
            quote_kind = (c == "\"") ? QUOTE_DOUBLE : QUOTE_SINGLE;
            scan_state = SC_QUOTED;
        end
        else
        begin
            quote_kind = QUOTE_NONE;
            value_hits = next_value(4'd0, c);
            scan_state = SC_BARE;
        end
    endfunction

    // Steps the line recognizer; returns 1 when this byte confirms a section tag.
    function automatic logic scan_char(input logic [7:0] c, input offs_t here);
        if (c == CH_CR || c == CH_LF)
        begin
            scan_state = SC_LINE_START;
            return 1'b0;
        end
        case (scan_state)
            SC_LINE_START:
            begin
                if (c == "<")
                begin
                    tag_start = here;
                    scan_state = SC_LT;
                end
                else if (c != CH_SP && c != CH_TAB)
                    scan_state = SC_LINE_REST;
                return 1'b0;
            end
            SC_LT:
            begin
                scan_state = (c == "d") ? SC_D : SC_LINE_REST;
                return 1'b0;
            end
            SC_D:
            begin
                scan_state = (c == "i") ? SC_I : SC_LINE_REST;
                return 1'b0;
            end
            SC_I:
            begin
                scan_state = (c == "v") ? SC_V : SC_LINE_REST;
                return 1'b0;
            end
            SC_V:
            begin
                pair_hit = 1'b0;
                name_hits = 3'd0;
                value_hits = 4'd0;
                quote_kind = QUOTE_NONE;
                scan_state = is_gap(c) ? SC_ATTR_GAP : SC_LINE_REST;
                return 1'b0;
            end
            SC_LINE_REST:
                return 1'b0;
            default:
                ;
        endcase

        // Inside the attribute area of a candidate tag.
        if (c == ">")
        begin
            if (scan_state == SC_QUOTED || scan_state == SC_BARE)
                check_pair();
            scan_state = SC_LINE_REST;
            return pair_hit;
        end
        case (scan_state)
            SC_ATTR_GAP:
            begin
                if (!is_gap(c))
                begin
                    name_hits = 3'd0;
                    if (is_name_char(c))
                    begin
                        name_hits = next_name(3'd0, c);
                        scan_state = SC_ATTR_NAME;
                    end
                    else if (c == "=")
                        scan_state = SC_VAL_GAP;
                    else
                        scan_state = SC_ATTR_SKIP;
                end
            end
            SC_ATTR_NAME:
            begin
                if (is_name_char(c))
                    name_hits = next_name(name_hits, c);
                else if (is_gap(c))
                    scan_state = SC_EQ_GAP;
                else if (c == "=")
                    scan_state = SC_VAL_GAP;
                else
                    scan_state = SC_ATTR_SKIP;
            end
            SC_EQ_GAP:
            begin
                if (c == "=")
                    scan_state = SC_VAL_GAP;
                else if (!is_gap(c))
                    scan_state = SC_ATTR_SKIP;
            end
            SC_ATTR_SKIP:
            begin
                if (is_gap(c))
                    scan_state = SC_ATTR_GAP;
            end
            SC_VAL_GAP:
            begin
                if (!is_gap(c))
                    open_value(c);
            end
            SC_QUOTED:
            begin
                if ((quote_kind == QUOTE_DOUBLE && c == "\"") ||
                    (quote_kind == QUOTE_SINGLE && c == "'"))
                begin
                    check_pair();
                    scan_state = SC_ATTR_GAP;
                end
                else
                    value_hits = next_value(value_hits, c);
            end
            SC_BARE:
            begin
                if (is_gap(c))
                begin
                    check_pair();
                    scan_state = SC_ATTR_GAP;
                end
                else
                    value_hits = next_value(value_hits, c);
            end
            default:
                scan_state = SC_LINE_REST;
        endcase
        return 1'b0;
    endfunction

    // Works out the spans caused by one accepted byte beat.
    task automatic predict_byte(input logic [7:0] c, input logic is_last);
        offs_t first;
        offs_t here;
        first = offs_t'(base_cfg);
        here = first + byte_count;
        if (scan_char(c, here))
        begin
            if (in_section)
                span_q.insert(span_q.size(),
                              {32'(section_start), 32'(tag_start - offs_t'(1)), 1'b0});
            section_start = tag_start;
            in_section = 1'b1;
        end
        if (is_last)
        begin
            span_q.insert(span_q.size(),
                          {32'(in_section ? section_start : first), 32'(here), 1'b1});
            byte_count = '0;
            scan_state = SC_LINE_START;
            name_hits = 3'd0;
            value_hits = 4'd0;
            quote_kind = QUOTE_NONE;
            pair_hit = 1'b0;
            tag_start = '0;
            section_start = '0;
            in_section = 1'b0;
        end
        else
            byte_count = byte_count + offs_t'(1);
    endtask

    task automatic log_fault(input string what, input span_t want, input span_t seen);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s: expected start=%h end=%h final=%b, got start=%h end=%h final=%b",
                     what, want.span_start, want.span_end, want.final_span,
                     seen.span_start, seen.span_end, seen.final_span);
    endtask

    // Byte driver: presents the head of the pending queue, holds it while stalled.
    always @(posedge clk or negedge rst_n)
    begin : feed_bytes
        logic taken;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
        end
        else
        begin
            taken = in_valid && !in_stall;
            if (taken)
            begin
                predict_byte(data_byte, last_byte);
                void'(byte_q.pop_front());
            end
            if (!in_valid || taken)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= byte_q[0].value;
                    last_byte <= byte_q[0].is_last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Span monitor: checks each accepted beat against the oldest expected span.
    always @(posedge clk or negedge rst_n)
    begin : check_spans
        span_t seen;
        span_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {span_start, span_end, final_span};
                if (span_q.size() == 0)
                    log_fault("span with none expected", '0, seen);
                else
                begin
                    want = span_q.pop_front();
                    if (seen.span_start !== want.span_start || seen.span_end !== want.span_end ||
                        seen.final_span !== want.final_span)
                        log_fault("span mismatch", want, seen);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Appends one byte to the record under construction.
    task automatic put_byte(input logic [7:0] b);
        rec_q.insert(rec_q.size(), b);
    endtask

    // Text builders for one record range.
    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_gap();
        case ($urandom_range(3))
            0: put_byte(CH_SP);
            1: put_byte(CH_TAB);
            2: put_byte(CH_VT);
            default: put_byte(CH_FF);
        endcase
    endtask

    task automatic put_lead();
        repeat ($urandom_range(2))
            put_byte($urandom_range(1) ? CH_SP : CH_TAB);
    endtask

    task automatic put_letters(input int n);
        repeat (n)
            put_byte(8'(8'h61 + $urandom_range(25)));
    endtask

    // Random bytes; line ends are kept out unless any byte is allowed.
    task automatic put_junk(input int n, input logic any_byte);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(255));
            if (!any_byte && (b == CH_CR || b == CH_LF))
                b = "x";
            put_byte(b);
        end
    endtask

    task automatic put_eol();
        case ($urandom_range(2))
            0: put_byte(CH_LF);
            1:
            begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
            default: put_byte(CH_CR);
        endcase
    endtask

    task automatic put_other_attr();
        case ($urandom_range(3))
            0: put_text("class=\"a b\"");
            1:
            begin
                put_text("id=");
                put_letters(3);
            end
            2: put_letters(4);
            default:
            begin
                put_text("data-x='");
                put_letters(2);
                put_text("'");
            end
        endcase
    endtask

    // The type attribute: the first five variants qualify, the rest are near misses.
    task automatic put_type_attr(input int kind);
        case (kind)
            0: put_text("type=\"section\"");
            1: put_text("type='section'");
            2: put_text("type=section");
            3:
            begin
                put_text("type");
                put_gap();
                put_text("=");
                put_gap();
                put_text("\"section\"");
            end
            4: put_text("type=\"section");
            5: put_text("type=\"sectio\"");
            6: put_text("types=\"section\"");
            7: put_text("TYPE=\"section\"");
            8: put_text("type=\"section'");
            9: put_text("type=sections");
            10: put_text("type==section");
            default: put_text("type=\"\"");
        endcase
    endtask

    task automatic put_tag_line(input logic stop_at_close);
        int kind;
        put_lead();
        put_text("<div");
        put_gap();
        repeat ($urandom_range(2))
        begin
            put_other_attr();
            if ($urandom_range(7) != 0)
                put_gap();
        end
        kind = $urandom_range(1) ? $urandom_range(4) : $urandom_range(11);
        put_type_attr(kind);
        if (kind != 4 && $urandom_range(2) == 0)
        begin
            put_gap();
            put_other_attr();
        end
        // Now and then the tag is left open to the end of the line.
        if ($urandom_range(7) != 0)
            put_text(">");
        if (stop_at_close)
            return;
        if ($urandom_range(5) == 0)
            put_text("<div type=section>");
        put_junk($urandom_range(6), 1'b0);
        put_eol();
    endtask

    task automatic put_line(input logic stop_at_close);
        int pick;
        pick = $urandom_range(19);
        if (pick <= 9)
            put_tag_line(stop_at_close);
        else if (pick <= 11)
        begin
            case ($urandom_range(4))
                0: put_text("<div>");
                1: put_text("<divx type=section>");
                2: put_text("<dv type=section>");
                3: put_text("x<div type=section>");
                default:
                begin
                    put_text("<div");
                    put_eol();
                    put_text("type=section>");
                end
            endcase
            put_eol();
        end
        else if (pick <= 14)
        begin
            put_junk($urandom_range(1, 20), 1'b0);
            put_eol();
        end
        else if (pick <= 16)
            put_junk($urandom_range(1, 12), 1'b1);
        else
        begin
            put_lead();
            put_eol();
        end
    endtask

    // Moves the built bytes to the pending queue, marking the last one if asked.
    task automatic queue_bytes(input logic close_range, output int n);
        n = rec_q.size();
        for (int i = 0; i < n; i++)
            byte_q.insert(byte_q.size(),
                          '{value: rec_q[i], is_last: close_range && (i == n - 1)});
        rec_q.delete();
    endtask

    task automatic make_range(output int n);
        int lines;
        int cut;
        rec_q.delete();
        lines = $urandom_range(1, 5);
        for (int i = 0; i < lines; i++)
            put_line(i == lines - 1 && $urandom_range(2) == 0);
        // Some ranges end in the middle of a line, a few after a single byte.
        if ($urandom_range(9) == 0)
        begin
            cut = $urandom_range(1, rec_q.size());
            while (rec_q.size() > cut)
                void'(rec_q.pop_back());
        end
        else if ($urandom_range(24) == 0)
        begin
            while (rec_q.size() > 1)
                void'(rec_q.pop_back());
        end
        queue_bytes(1'b1, n);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || in_valid || span_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_cfg  = v;
        @(negedge clk);
    endtask

    // One phase: the sender holds off until every span is in, then the base
    // offset and the idle mix change and random ranges follow.
    task automatic run_phase(input logic [31:0] base, input int idle_pct,
                             input int stall_pct, input int n_items);
        int added;
        int n;
        wait_drained();
        write_base(base);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        added = 0;
        while (added < n_items)
        begin
            make_range(n);
            added += n;
        end
    endtask

    initial
    begin : run_test
        int n;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a section tag after a tab, CRLF, byte extremes, a range
        // end, then a range left open across a base offset change.
        run_phase(32'h0000_0000, 0, 0, 0);
        put_text("\t<div type=section>");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(8'hFF);
        put_byte(8'h00);
        queue_bytes(1'b1, n);
        put_text("<d");
        queue_bytes(1'b0, n);

        run_phase(32'hFFFF_FFF8, 0, 0, 350);
        run_phase(32'hFFFF_FFFF, 75, 0, 400);
        run_phase($urandom, 0, 75, 400);
        run_phase(32'hFFFF_FF80, 38, 38, 400);
        run_phase(32'h8000_0000, 38, 38, 300);
        wait_drained();

        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
